// ===== src/ihp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, operation and status codes, and the result item struct
// for the indexed max-heap. No dependencies.
package ihp_pkg;

   localparam int CAPACITY_DEF = 64;

   // fixed field widths of the item channels
   localparam int KIND_W   = 2;
   localparam int KEY_W    = 32;
   localparam int POS_W    = 6;
   localparam int HND_W    = 6;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 7;

   localparam int REQ_DATA_W = ((KEY_W + POS_W + HND_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((KEY_W + HND_W + CNT_W + 7) / 8) * 8;
   localparam int REQ_PAD_W  = REQ_DATA_W - (KEY_W + POS_W + HND_W);
   localparam int RSP_PAD_W  = RSP_DATA_W - (KEY_W + HND_W + CNT_W);

   // operation kinds
   localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UPD_POS = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UPD_HND = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [KEY_W-1:0] out_key;
      logic [HND_W-1:0]        out_handle;
      logic [CNT_W-1:0]        entry_count;
   } rsp_item_type;

endpackage

// ===== src/ihp_ram.sv =====
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, two read ports, read data registered.
// Depends on ihp_pkg for default sizes only.
module ihp_ram #(
   parameter int WIDTH = ihp_pkg::KEY_W,
   parameter int DEPTH = ihp_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== src/ihp_out.sv =====
`timescale 1ns / 1ps
// Result item register on the rsp_ stream side, so the core can take a new
// item while a finished result waits. Depends on ihp_pkg.
module ihp_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  ihp_pkg::rsp_item_type               item,
   output logic                                free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_key [31:0], out_handle [37:32], entry_count [44:38], zero pad above
   output logic [ihp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status
   output logic [ihp_pkg::STATUS_W-1:0]        rsp_tuser
);

   logic                  valid_ff;
   logic                  valid_in;
   ihp_pkg::rsp_item_type item_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{ihp_pkg::RSP_PAD_W{1'b0}}, item_ff.entry_count,
                        item_ff.out_handle, item_ff.out_key};
   assign rsp_tuser  = item_ff.status;

endmodule

// ===== src/indexed_max_heap.sv =====
`timescale 1ns / 1ps
// Indexed binary max-heap: sequencer around two synchronous memories.
// Depends on ihp_pkg, ihp_ram and ihp_out.
//
//  channel | direction | tdata                                   | tuser
//  req_    | in        | key[31:0] position[37:32] handle[43:38] | kind
//  rsp_    | out       | out_key[31:0] out_handle[37:32]         | status
//          |           | entry_count[44:38]                      |
//
// Memory A holds {key, handle} by heap position, memory B the position of each
// handle. Each sift level is a read state then a compare/write state on the memory
// ports. A push sifts up, a pop sinks the old tail entry from the root, and an
// update sifts up then down. Rejected items go straight to S_FIN; a handle
// update first looks up the handle's position and is rejected if it is not live.
// After reset a clearing pass loads both maps with the identity; req_tready stays
// low meanwhile.
// A result that is not taken holds the core in its final state, one item deep.
module indexed_max_heap #(
   parameter int CAPACITY = ihp_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // key [31:0], position [37:32], handle [43:38], zero pad above
   input  logic [ihp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind
   input  logic [ihp_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_key [31:0], out_handle [37:32], entry_count [44:38], zero pad above
   output logic [ihp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [ihp_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;
   localparam int KW = ihp_pkg::KEY_W;
   localparam int MW = KW + AW;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_PUSH_RD = 4'd2;
   localparam logic [3:0] S_POP_RD  = 4'd3;
   localparam logic [3:0] S_UPD_RD  = 4'd4;
   localparam logic [3:0] S_LOOK    = 4'd5;
   localparam logic [3:0] S_UP      = 4'd6;
   localparam logic [3:0] S_UP_CMP  = 4'd7;
   localparam logic [3:0] S_DN      = 4'd8;
   localparam logic [3:0] S_DN_CMP  = 4'd9;
   localparam logic [3:0] S_FIN     = 4'd10;

   // request fields
   logic [ihp_pkg::KIND_W-1:0]  req_kind;
   logic signed [KW-1:0]        req_key;
   logic [ihp_pkg::POS_W-1:0]   req_pos;
   logic [ihp_pkg::HND_W-1:0]   req_hnd;
   logic                        accept;

   assign req_kind = req_tuser;
   assign req_key  = $signed(req_tdata[KW-1:0]);
   assign req_pos  = req_tdata[KW +: ihp_pkg::POS_W];
   assign req_hnd  = req_tdata[KW + ihp_pkg::POS_W +: ihp_pkg::HND_W];

   // state
   logic [3:0]                     state_ff, state_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic [AW-1:0]                  pos_ff, pos_in;
   logic signed [KW-1:0]           elem_key_ff, elem_key_in;
   logic [AW-1:0]                  elem_hnd_ff, elem_hnd_in;
   logic                           sink_ff, sink_in;
   logic                           wr_elem_ff, wr_elem_in;
   logic [ihp_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic signed [KW-1:0]           okey_ff, okey_in;
   logic [AW-1:0]                  ohnd_ff, ohnd_in;

   // memory ports
   logic            wa_en, wb_en;
   logic [AW-1:0]   wa_addr, wb_addr;
   logic [MW-1:0]   wa_data;
   logic [AW-1:0]   wb_data;
   logic [AW-1:0]   ra0_addr, ra1_addr, rb_addr;
   logic [MW-1:0]   rda0, rda1;
   logic [AW-1:0]   rdb;

   logic signed [KW-1:0] rd_key0, rd_key1, cmp_key;
   logic [AW-1:0]        rd_hnd0, rd_hnd1;
   logic [AW-1:0]        up_idx;
   logic [XW-1:0]        lft_idx, rgt_idx;
   logic                 l_win, r_win, r_ok;

   logic                  rsp_load;
   logic                  rsp_free;
   ihp_pkg::rsp_item_type rsp_item;

   assign rd_key0 = $signed(rda0[AW +: KW]);
   assign rd_key1 = $signed(rda1[AW +: KW]);
   assign rd_hnd0 = rda0[AW-1:0];
   assign rd_hnd1 = rda1[AW-1:0];

   assign up_idx  = (pos_ff - 1'b1) >> 1;
   assign lft_idx = (XW'(pos_ff) << 1) + 1'b1;
   assign rgt_idx = lft_idx + 1'b1;

   // left child wins only on strictly greater, right must beat the current best
   assign l_win   = rd_key0 > elem_key_ff;
   assign cmp_key = l_win ? rd_key0 : elem_key_ff;
   assign r_ok    = rgt_idx < XW'(cnt_ff);
   assign r_win   = r_ok && (rd_key1 > cmp_key);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      pos_in      = pos_ff;
      elem_key_in = elem_key_ff;
      elem_hnd_in = elem_hnd_ff;
      sink_in     = sink_ff;
      wr_elem_in  = wr_elem_ff;
      status_in   = status_ff;
      okey_in     = okey_ff;
      ohnd_in     = ohnd_ff;
      wa_en       = 1'b0;
      wa_addr     = '0;
      wa_data     = '0;
      wb_en       = 1'b0;
      wb_addr     = '0;
      wb_data     = '0;
      ra0_addr    = '0;
      ra1_addr    = '0;
      rb_addr     = '0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wa_en   = 1'b1;
            wa_addr = clr_ff;
            wa_data = {{KW{1'b0}}, clr_ff};
            wb_en   = 1'b1;
            wb_addr = clr_ff;
            wb_data = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               status_in   = ihp_pkg::ST_OK;
               okey_in     = '0;
               ohnd_in     = '0;
               elem_key_in = req_key;
               wr_elem_in  = 1'b1;
               sink_in     = 1'b1;
               unique case (req_kind)
                  ihp_pkg::KIND_PUSH: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        status_in  = ihp_pkg::ST_FULL;
                        wr_elem_in = 1'b0;
                        state_in   = S_FIN;
                     end else begin
                        ra0_addr = AW'(cnt_ff);
                        pos_in   = AW'(cnt_ff);
                        sink_in  = 1'b0;
                        state_in = S_PUSH_RD;
                     end
                  end
                  ihp_pkg::KIND_POP: begin
                     if (cnt_ff == '0) begin
                        status_in  = ihp_pkg::ST_EMPTY;
                        wr_elem_in = 1'b0;
                        state_in   = S_FIN;
                     end else begin
                        ra0_addr = '0;
                        ra1_addr = AW'(cnt_ff - 1'b1);
                        state_in = S_POP_RD;
                     end
                  end
                  ihp_pkg::KIND_UPD_POS: begin
                     if (32'(req_pos) >= 32'(cnt_ff)) begin
                        status_in  = ihp_pkg::ST_RANGE;
                        wr_elem_in = 1'b0;
                        state_in   = S_FIN;
                     end else begin
                        ra0_addr = AW'(req_pos);
                        pos_in   = AW'(req_pos);
                        state_in = S_UPD_RD;
                     end
                  end
                  ihp_pkg::KIND_UPD_HND: begin
                     if (32'(req_hnd) >= 32'(CAPACITY)) begin
                        status_in  = ihp_pkg::ST_RANGE;
                        wr_elem_in = 1'b0;
                        state_in   = S_FIN;
                     end else begin
                        rb_addr  = AW'(req_hnd);
                        state_in = S_LOOK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PUSH_RD: begin
            // the handle parked at the free tail goes to the new entry
            elem_hnd_in = rd_hnd0;
            ohnd_in     = rd_hnd0;
            cnt_in      = cnt_ff + 1'b1;
            state_in    = S_UP;
         end
         S_POP_RD: begin
            // popped top parks at the old tail, old tail entry sinks from the root
            okey_in     = rd_key0;
            ohnd_in     = rd_hnd0;
            wa_en       = 1'b1;
            wa_addr     = AW'(cnt_ff - 1'b1);
            wa_data     = rda0;
            wb_en       = 1'b1;
            wb_addr     = rd_hnd0;
            wb_data     = AW'(cnt_ff - 1'b1);
            elem_key_in = rd_key1;
            elem_hnd_in = rd_hnd1;
            pos_in      = '0;
            cnt_in      = cnt_ff - 1'b1;
            state_in    = S_DN;
         end
         S_LOOK: begin
            if (32'(rdb) >= 32'(cnt_ff)) begin
               status_in  = ihp_pkg::ST_RANGE;
               wr_elem_in = 1'b0;
               state_in   = S_FIN;
            end else begin
               ra0_addr = rdb;
               pos_in   = rdb;
               state_in = S_UPD_RD;
            end
         end
         S_UPD_RD: begin
            elem_hnd_in = rd_hnd0;
            state_in    = S_UP;
         end
         S_UP: begin
            if (pos_ff == '0) begin
               state_in = sink_ff ? S_DN : S_FIN;
            end else begin
               ra0_addr = up_idx;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (rd_key0 < elem_key_ff) begin
               // parent moves down into the hole
               wa_en    = 1'b1;
               wa_addr  = pos_ff;
               wa_data  = rda0;
               wb_en    = 1'b1;
               wb_addr  = rd_hnd0;
               wb_data  = pos_ff;
               pos_in   = up_idx;
               state_in = S_UP;
            end else begin
               state_in = sink_ff ? S_DN : S_FIN;
            end
         end
         S_DN: begin
            if (lft_idx >= XW'(cnt_ff)) begin
               state_in = S_FIN;
            end else begin
               ra0_addr = AW'(lft_idx);
               ra1_addr = AW'(rgt_idx);
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (r_win || l_win) begin
               // winning child moves up into the hole
               wa_en    = 1'b1;
               wa_addr  = pos_ff;
               wa_data  = r_win ? rda1 : rda0;
               wb_en    = 1'b1;
               wb_addr  = r_win ? rd_hnd1 : rd_hnd0;
               wb_data  = pos_ff;
               pos_in   = r_win ? AW'(rgt_idx) : AW'(lft_idx);
               state_in = S_DN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (wr_elem_ff) begin
                  wa_en   = 1'b1;
                  wa_addr = pos_ff;
                  wa_data = {elem_key_ff, elem_hnd_ff};
                  wb_en   = 1'b1;
                  wb_addr = elem_hnd_ff;
                  wb_data = pos_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         clr_ff   <= clr_in;
      end
      pos_ff      <= pos_in;
      elem_key_ff <= elem_key_in;
      elem_hnd_ff <= elem_hnd_in;
      sink_ff     <= sink_in;
      wr_elem_ff  <= wr_elem_in;
      status_ff   <= status_in;
      okey_ff     <= okey_in;
      ohnd_ff     <= ohnd_in;
   end

   ihp_ram #(
      .WIDTH (MW),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock     (clock),
      .wr_en     (wa_en),
      .wr_addr   (wa_addr),
      .wr_data   (wa_data),
      .rd_addr_a (ra0_addr),
      .rd_addr_b (ra1_addr),
      .rd_data_a (rda0),
      .rd_data_b (rda1)
   );

   ihp_ram #(
      .WIDTH (AW),
      .DEPTH (CAPACITY)
   ) u_where_ram (
      .clock     (clock),
      .wr_en     (wb_en),
      .wr_addr   (wb_addr),
      .wr_data   (wb_data),
      .rd_addr_a (rb_addr),
      .rd_addr_b ('0),
      .rd_data_a (rdb),
      .rd_data_b ()
   );

   always_comb begin
      rsp_item.status      = status_ff;
      rsp_item.out_key     = okey_ff;
      rsp_item.out_handle  = ihp_pkg::HND_W'(ohnd_ff);
      rsp_item.entry_count = ihp_pkg::CNT_W'(cnt_ff);
   end

   ihp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (rsp_load),
      .item       (rsp_item),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(CAPACITY))
      else $error("entry count above capacity");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (cnt_ff == $past(cnt_ff) || cnt_ff == $past(cnt_ff) + 1'b1 ||
                cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("entry count jumped by more than one");

   a_up_not_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UP_CMP |-> pos_ff != '0)
      else $error("sift up compare at the root");

   a_maps_together: assert property (@(posedge clock) disable iff (reset)
      wa_en == wb_en)
      else $error("entry and handle maps written apart");

   a_accept_vs_load: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_load)
      else $error("item taken while a result is loaded");

endmodule
